/* hw/rtl/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  // Default fraction bits of the Q1.F inputs
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Register stages from input to output register
  localparam int unsigned PIPE_STAGES = 6;

  // Width of one color channel
  localparam int unsigned CHAN_W = 8;

  // Hue sector, one sixth of a turn each
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red to yellow
    SEC_YG = 3'd1,  // yellow to green
    SEC_GC = 3'd2,  // green to cyan
    SEC_CB = 3'd3,  // cyan to blue
    SEC_BM = 3'd4,  // blue to magenta
    SEC_MR = 3'd5   // magenta to red
  } sector_t;

endpackage

/* hw/rtl/hsv_to_rgb_converter.sv */
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+------------------------------------------
// s_axis   | in  | tvalid / tready     | tdata: hue, saturation, brightness
// m_axis   | out | tvalid / tready     | tdata: red, green, blue
//
// One word per cycle sustained while m_axis_tready holds; a word moves from stage one
// through the stage registers in order, and m_axis_tvalid rises when it is in stage six.
// rst is synchronous and active high; it clears the stage valid bits only.
// A stall at m_axis backs up stage by stage; empty stages still take words,
// so s_axis_tready drops only once every stage holds a word.
module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W = ((3 * (FRAC_BITS + 1) + 7) / 8) * 8,
  localparam int unsigned OUT_W = 3 * hsv2rgb_pkg::CHAN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // hue, saturation, brightness (F+1 bits each)
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // red, green, blue (8 bits each)
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned IW = F + 1;       // input field width
  localparam int unsigned PW = 2 * F + 1;   // width of products up to ONE^2
  localparam int unsigned XW = 3 * F + 1;   // width of products up to ONE^3
  localparam int unsigned NS = hsv2rgb_pkg::PIPE_STAGES;
  localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;

  localparam logic [IW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] ONE2 = {1'b1, {(2 * F){1'b0}}};

  // Saturate a field to one
  function automatic logic [IW-1:0] clamp_one(input logic [IW-1:0] x);
    return (x[F] && (|x[F-1:0])) ? ONE : x;
  endfunction

  // floor(p * 255 / 2^(3F)), p at most ONE^3
  function automatic logic [CW-1:0] scale_chan(input logic [XW-1:0] p);
    logic [XW+7:0] m;
    m = {p, 8'b0} - {8'b0, p};
    return m[XW+6:XW-1];
  endfunction

  // Stage handshake
  logic [NS:1] vld;
  logic [NS:1] rdy;

  always_comb begin
    rdy[NS] = !vld[NS] || m_axis_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: clamp fields, split hue into sector and fraction
  logic [IW-1:0]        hue_c, sat_c, bri_c;
  logic [F+2:0]         h6;
  logic [IW-1:0]        s1, v1;
  logic [F-1:0]         f1;
  hsv2rgb_pkg::sector_t sec1;

  assign hue_c = clamp_one(s_axis_tdata[IW-1:0]);
  assign sat_c = clamp_one(s_axis_tdata[2*IW-1:IW]);
  assign bri_c = clamp_one(s_axis_tdata[3*IW-1:2*IW]);
  assign h6    = {hue_c, 2'b0} + {1'b0, hue_c, 1'b0};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1 <= sat_c;
      v1 <= bri_c;
      if (hue_c[F]) begin
        sec1 <= hsv2rgb_pkg::SEC_RY;
        f1   <= '0;
      end else begin
        sec1 <= hsv2rgb_pkg::sector_t'(h6[F+2:F]);
        f1   <= h6[F-1:0];
      end
    end
  end

  // Stage 2: s*f and s*(1-f)
  logic [IW-1:0]        one_mf;
  logic [PW-1:0]        sf_full;
  logic [2*IW-1:0]      sg_full;
  logic [PW-1:0]        sf2, sg2;
  logic [IW-1:0]        ns2, v2;
  hsv2rgb_pkg::sector_t sec2;

  assign one_mf  = ONE - {1'b0, f1};
  assign sf_full = s1 * f1;
  assign sg_full = s1 * one_mf;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sf2  <= sf_full;
      sg2  <= sg_full[PW-1:0];
      ns2  <= ONE - s1;
      v2   <= v1;
      sec2 <= sec1;
    end
  end

  // Stage 3: 1 - s*f and 1 - s*(1-f)
  logic [PW-1:0]        xq3, xt3;
  logic [IW-1:0]        ns3, v3;
  hsv2rgb_pkg::sector_t sec3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      xq3  <= ONE2 - sf2;
      xt3  <= ONE2 - sg2;
      ns3  <= ns2;
      v3   <= v2;
      sec3 <= sec2;
    end
  end

  // Stage 4: v times the high and low halves of each factor, and v*(1-s)
  logic [2*IW-1:0]      qh_full, th_full, pp_full;
  logic [PW-1:0]        ql_full, tl_full;
  logic [2*IW-1:0]      qh4, th4, pp4;
  logic [PW-1:0]        ql4, tl4;
  logic [IW-1:0]        v4;
  hsv2rgb_pkg::sector_t sec4;

  assign qh_full = v3 * xq3[PW-1:F];
  assign ql_full = v3 * xq3[F-1:0];
  assign th_full = v3 * xt3[PW-1:F];
  assign tl_full = v3 * xt3[F-1:0];
  assign pp_full = v3 * ns3;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      qh4  <= qh_full;
      ql4  <= ql_full;
      th4  <= th_full;
      tl4  <= tl_full;
      pp4  <= pp_full;
      v4   <= v3;
      sec4 <= sec3;
    end
  end

  // Stage 5: join the partial products into full-precision values
  logic [XW:0]          pq_sum, pt_sum, pp_ext;
  logic [XW-1:0]        pv5, pp5, pq5, pt5;
  hsv2rgb_pkg::sector_t sec5;

  assign pq_sum = {qh4, {F{1'b0}}} + {{(F + 1){1'b0}}, ql4};
  assign pt_sum = {th4, {F{1'b0}}} + {{(F + 1){1'b0}}, tl4};
  assign pp_ext = {pp4, {F{1'b0}}};

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pv5  <= {v4, {(2 * F){1'b0}}};
      pp5  <= pp_ext[XW-1:0];
      pq5  <= pq_sum[XW-1:0];
      pt5  <= pt_sum[XW-1:0];
      sec5 <= sec4;
    end
  end

  // Stage 6: scale by 255, route by sector into the output register
  logic [CW-1:0] cv, cp, cq, ct;
  logic [CW-1:0] r_next, g_next, b_next;
  logic [CW-1:0] red, green, blue;

  assign cv = scale_chan(pv5);
  assign cp = scale_chan(pp5);
  assign cq = scale_chan(pq5);
  assign ct = scale_chan(pt5);

  always_comb begin
    case (sec5)
      hsv2rgb_pkg::SEC_RY: begin r_next = cv; g_next = ct; b_next = cp; end
      hsv2rgb_pkg::SEC_YG: begin r_next = cq; g_next = cv; b_next = cp; end
      hsv2rgb_pkg::SEC_GC: begin r_next = cp; g_next = cv; b_next = ct; end
      hsv2rgb_pkg::SEC_CB: begin r_next = cp; g_next = cq; b_next = cv; end
      hsv2rgb_pkg::SEC_BM: begin r_next = ct; g_next = cp; b_next = cv; end
      default:             begin r_next = cv; g_next = cp; b_next = cq; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

  assign m_axis_tvalid = vld[NS];
  assign m_axis_tdata  = {blue, green, red};

`ifndef SYNTHESIS
  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // The two hue products share saturation: s*f + s*(1-f) == s
  a_prod_sum: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> ({1'b0, sf2} + {1'b0, sg2}) == {1'b0, ONE - ns2, {F{1'b0}}})
    else $error("hue products inconsistent with saturation");

  // A stalled middle stage keeps its word
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !rdy[3]) |=> (vld[3] && $stable(xq3) && $stable(xt3)))
    else $error("stage 3 word changed under stall");

  // Joined products never exceed one cubed
  a_prod_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (pq5 <= {1'b1, {(3 * F){1'b0}}}) && (pt5 <= {1'b1, {(3 * F){1'b0}}}))
    else $error("channel product out of range");
`endif

endmodule
